@@ hw/rtl/rational_arithmetic_unit_defines.svh @@
// assertion macros for the rational arithmetic unit
// used by rau_back and rau_front
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH

// condition checked every clock, disabled in reset
`define RAU_ASSERT(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// next-cycle implication
`define RAU_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

@@ hw/rtl/rau_pkg.sv @@
// shared types and constants for the rational arithmetic unit
// no dependencies
`default_nettype none
package rau_pkg;
	localparam int unsigned FifoDepthDefault = 2;

	typedef enum logic [1:0] {
		ACT_ADD = 2'd0,
		ACT_SUB = 2'd1,
		ACT_MUL = 2'd2,
		ACT_DIV = 2'd3
	} action_t;

	// classified word handed from front to back
	typedef struct packed {
		logic signed [31:0] num;
		logic signed [31:0] den;
		logic               zero_den;
	} raw_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GCD,
		ST_DIVN,
		ST_DIVD,
		ST_DONE
	} back_state_t;
endpackage
`default_nettype wire

@@ hw/rtl/rau_div.sv @@
// iterative 32-bit signed truncating divider, one quotient bit per cycle
// depends on rau_pkg
`default_nettype none
module rau_div import rau_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [31:0] dividend,
	input  wire logic signed [31:0] divisor,
	output logic                    busy,
	output logic                    done,
	output logic signed [31:0]      quot,
	output logic signed [31:0]      rem
);
	logic [31:0] q_q, r_q, d_q;
	logic [5:0]  cnt_q;
	logic        qneg_q, rneg_q, busy_q, done_q;
	logic [32:0] trial;
	logic [31:0] rsh;

	assign rsh   = {r_q[30:0], q_q[31]};
	assign trial = {1'b0, rsh} - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// magnitudes, restoring shift-subtract
	always_ff @(posedge clk) begin
		if (start) begin
			q_q    <= dividend[31] ? 32'(-dividend) : dividend;
			d_q    <= divisor[31] ? 32'(-divisor) : divisor;
			r_q    <= '0;
			qneg_q <= dividend[31] ^ divisor[31];
			rneg_q <= dividend[31];
		end else if (busy_q) begin
			if (!trial[32]) begin
				r_q <= trial[31:0];
				q_q <= {q_q[30:0], 1'b1};
			end else begin
				r_q <= rsh;
				q_q <= {q_q[30:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = qneg_q ? -$signed(q_q) : $signed(q_q);
	assign rem  = rneg_q ? -$signed(r_q) : $signed(r_q);
endmodule
`default_nettype wire

@@ hw/rtl/rau_front.sv @@
// front: accepts words, forms and combines cross products in registered stages, queues raw fraction
// depends on rau_pkg
`default_nettype none
`include "rational_arithmetic_unit_defines.svh"
module rau_front import rau_pkg::*; #(
	parameter int unsigned FifoDepth = FifoDepthDefault
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               valid,
	output logic                    stall,
	input  wire logic [1:0]         action,
	input  wire logic signed [15:0] a_num,
	input  wire logic signed [15:0] a_den,
	input  wire logic signed [15:0] b_num,
	input  wire logic signed [15:0] b_den,
	output logic                    raw_valid,
	input  wire logic               raw_take,
	output raw_t                    raw
);
	localparam int unsigned AW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;

	logic               v_s1, v_s2;
	logic [1:0]         act_s1;
	logic signed [31:0] p0_s1, p1_s1, dd_s1;
	raw_t               raw_s2;
	raw_t               mem [FifoDepth];
	logic [AW-1:0]      wp_q, rp_q;
	logic [AW:0]        cnt_q;
	logic               push, pop, adv;
	logic signed [31:0] n_c;

	// advance unless stage two holds a word and the queue is full
	assign adv   = !(v_s2 && (cnt_q == AW'(0) + (AW+1)'(FifoDepth)));
	assign push  = v_s2 && adv;
	assign pop   = raw_take;
	assign stall = !(adv) || (v_s1 && !adv);

	always_comb begin
		case (action_t'(act_s1))
			ACT_ADD: n_c = p0_s1 + p1_s1;
			ACT_SUB: n_c = p0_s1 - p1_s1;
			default: n_c = p0_s1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (adv) begin
				v_s1 <= valid;
				v_s2 <= v_s1;
			end
			if (push) wp_q <= (wp_q == AW'(FifoDepth - 1)) ? '0 : wp_q + AW'(1);
			if (pop)  rp_q <= (rp_q == AW'(FifoDepth - 1)) ? '0 : rp_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s1 <= action;
			case (action_t'(action))
				ACT_MUL: begin
					p0_s1 <= 32'(a_num * b_num);
					dd_s1 <= 32'(a_den * b_den);
				end
				ACT_DIV: begin
					p0_s1 <= 32'(a_num * b_den);
					dd_s1 <= 32'(a_den * b_num);
				end
				default: begin
					p0_s1 <= 32'(a_num * b_den);
					dd_s1 <= 32'(a_den * b_den);
				end
			endcase
			p1_s1           <= 32'(b_num * a_den);
			raw_s2.num      <= n_c;
			raw_s2.den      <= dd_s1;
			raw_s2.zero_den <= (dd_s1 == 32'sd0);
		end
		if (push) mem[wp_q] <= raw_s2;
	end

	assign raw_valid = (cnt_q != '0);
	assign raw       = mem[rp_q];

	`RAU_ASSERT(a_no_overflow, cnt_q <= (AW+1)'(FifoDepth), "queue overflow")
	`RAU_ASSERT(a_no_underflow, !(pop && cnt_q == '0), "queue underflow")
	`RAU_ASSERT_NEXT(a_stage_hold, v_s2 && !adv, v_s2, "stage two lost while blocked")
endmodule
`default_nettype wire

@@ hw/rtl/rau_back.sv @@
// back: Euclid gcd and two exact divisions on a shared divider, output register
// depends on rau_pkg, rau_div
`default_nettype none
`include "rational_arithmetic_unit_defines.svh"
module rau_back import rau_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        raw_valid,
	output logic             raw_take,
	input  raw_t             raw,
	output logic             valid,
	input  wire logic        stall,
	output logic signed [31:0] result_num,
	output logic signed [31:0] result_den,
	output logic             error_code
);
	back_state_t        state_q, state_d;
	logic signed [31:0] n_q, d_q, x_q, y_q, rn_q, rd_q;
	logic               err_q, ov_q;
	logic               ds, dbusy, ddone;
	logic signed [31:0] da, db, dq, dr;

	rau_div u_div (
		.clk(clk), .arst_n(arst_n), .start(ds), .dividend(da), .divisor(db),
		.busy(dbusy), .done(ddone), .quot(dq), .rem(dr)
	);

	assign raw_take = (state_q == ST_IDLE) && raw_valid;

	always_comb begin
		state_d = state_q;
		ds      = 1'b0;
		da      = x_q;
		db      = y_q;
		unique case (state_q)
			ST_IDLE: if (raw_valid) begin
				if (raw.zero_den) state_d = ST_DONE;
				else begin
					ds      = 1'b1;
					da      = raw.num;
					db      = raw.den;
					state_d = ST_GCD;
				end
			end
			ST_GCD: if (ddone) begin
				if (dr == 32'sd0) begin
					ds      = 1'b1;
					da      = n_q;
					db      = y_q;
					state_d = ST_DIVN;
				end else begin
					ds = 1'b1;
					da = y_q;
					db = dr;
				end
			end
			ST_DIVN: if (ddone) begin
				ds      = 1'b1;
				da      = d_q;
				db      = x_q;
				state_d = ST_DIVD;
			end
			ST_DIVD: if (ddone) state_d = ST_DONE;
			ST_DONE: if (!ov_q || !stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ov_q && !stall) ov_q <= 1'b0;
			if (state_q == ST_DONE && (!ov_q || !stall)) ov_q <= 1'b1;
		end
	end

	// x holds gcd divisor between divisions; y the current divisor
	always_ff @(posedge clk) begin
		if (state_q == ST_GCD && ddone && dr == 32'sd0) x_q <= y_q;
		else if (ds && state_q != ST_DIVN) begin
			x_q <= da;
			y_q <= db;
		end
		if (state_q == ST_IDLE && raw_valid) begin
			n_q   <= raw.num;
			d_q   <= raw.den;
			err_q <= raw.zero_den;
			rn_q  <= '0;
			rd_q  <= '0;
		end
		if (state_q == ST_DIVN && ddone) rn_q <= dq;
		if (state_q == ST_DIVD && ddone) rd_q <= dq;
		if (state_q == ST_DONE && (!ov_q || !stall)) begin
			result_num <= rn_q;
			result_den <= rd_q;
			error_code <= err_q;
		end
	end

	assign valid = ov_q;

	`RAU_ASSERT(a_take_idle, !raw_take || state_q == ST_IDLE, "take outside idle")
	`RAU_ASSERT(a_div_start, !(ds && dbusy), "divider restarted while busy")
	`RAU_ASSERT_NEXT(a_err_zero, ov_q && error_code && stall,
		result_num == 32'sd0 && result_den == 32'sd0, "error word not zero")
endmodule
`default_nettype wire

@@ hw/rtl/rational_arithmetic_unit.sv @@
// top level of the rational arithmetic unit
// depends on rau_pkg, rau_front, rau_back
//
// channel  dir  handshake      fields
// in       in   valid/stall    action a_num a_den b_num b_den
// out      out  out_valid/out_stall  result_num result_den error_code
//
// the front registers the cross products, then their sum or difference, then a short queue
// back: gcd takes up to about 46 divides, then two more divides
// zero denominator words skip the divider and go straight from idle to done
// reset clears control only; a stalled output holds its word while the back waits
`default_nettype none
module rational_arithmetic_unit import rau_pkg::*; #(
	parameter int unsigned FifoDepth = FifoDepthDefault
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               valid,
	output logic                    stall,
	input  wire logic [1:0]         action,
	input  wire logic signed [15:0] a_num,
	input  wire logic signed [15:0] a_den,
	input  wire logic signed [15:0] b_num,
	input  wire logic signed [15:0] b_den,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      result_num,
	output logic signed [31:0]      result_den,
	output logic                    error_code
);
	logic raw_valid, raw_take;
	raw_t raw;

	rau_front #(.FifoDepth(FifoDepth)) u_front (
		.clk(clk), .arst_n(arst_n), .valid(valid), .stall(stall), .action(action),
		.a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
		.raw_valid(raw_valid), .raw_take(raw_take), .raw(raw)
	);

	rau_back u_back (
		.clk(clk), .arst_n(arst_n), .raw_valid(raw_valid), .raw_take(raw_take),
		.raw(raw), .valid(out_valid), .stall(out_stall), .result_num(result_num),
		.result_den(result_den), .error_code(error_code)
	);
endmodule
`default_nettype wire
